[hdl/mns_pkg.sv]
// Shared types and constants for the melody note sequencer.
package mns_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PRESS = 2'd1,
    OP_LOAD  = 2'd2
  } op_t;

  // Button codes, also bit positions in the pending press mask
  localparam logic [2:0] BTN_PLAY   = 3'd0;
  localparam logic [2:0] BTN_RESET  = 3'd1;
  localparam logic [2:0] BTN_SLOW   = 3'd2;
  localparam logic [2:0] BTN_FAST   = 3'd3;
  localparam logic [2:0] BTN_CHANGE = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_TEMPO_DEFAULT = 3'd0;
  localparam logic [2:0] CFG_TEMPO_STEP    = 3'd1;
  localparam logic [2:0] CFG_SLOW_LIMIT    = 3'd2;
  localparam logic [2:0] CFG_FAST_LIMIT    = 3'd3;
  localparam logic [2:0] CFG_DEBOUNCE      = 3'd4;
  localparam logic [2:0] CFG_FIRST_LENGTH  = 3'd5;
  localparam logic [2:0] CFG_SECOND_LENGTH = 3'd6;

  localparam int CFG_DATA_W = 9;

  // Register reset values
  localparam logic [7:0] RST_TEMPO_DEFAULT = 8'd53;
  localparam logic [5:0] RST_TEMPO_STEP    = 6'd10;
  localparam logic [7:0] RST_SLOW_LIMIT    = 8'd200;
  localparam logic [7:0] RST_FAST_LIMIT    = 8'd10;
  localparam logic [7:0] RST_DEBOUNCE      = 8'd20;
  localparam logic [8:0] RST_FIRST_LENGTH  = 9'd72;
  localparam logic [8:0] RST_SECOND_LENGTH = 9'd246;

  // One song memory entry
  typedef struct packed {
    logic [15:0] period;
    logic [9:0]  duration;
  } note_entry_t;

  // Configuration register set
  typedef struct packed {
    logic [7:0] tempo_default;
    logic [5:0] tempo_step;
    logic [7:0] slow_limit;
    logic [7:0] fast_limit;
    logic [7:0] debounce;
    logic [8:0] first_length;
    logic [8:0] second_length;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic [15:0] tone_period;
    logic        tone_enabled;
    logic        red_led;
    logic        green_led;
    logic        current_song;
    logic [7:0]  note_position;
  } result_t;

endpackage

[hdl/mns_song_mem.sv]
// Song memory: note periods and durations, synchronous read with write-first forwarding.
module mns_song_mem #(
  parameter int SONG_DEPTH = 256,
  parameter int SONG_COUNT = 2
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        wr_en,
  input  logic [$clog2(SONG_COUNT*SONG_DEPTH)-1:0]    wr_addr,
  input  mns_pkg::note_entry_t                        wr_entry,
  input  logic [$clog2(SONG_COUNT*SONG_DEPTH)-1:0]    rd_addr,
  output mns_pkg::note_entry_t                        rd_entry,
  output logic [$clog2(SONG_COUNT*SONG_DEPTH)-1:0]    rd_tag,
  output logic                                        rd_valid
);

  localparam int ENTRIES = SONG_COUNT * SONG_DEPTH;

  mns_pkg::note_entry_t mem [ENTRIES];

  // Write port and registered read; a write to the address being read wins
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_entry <= wr_entry;
    end else begin
      rd_entry <= mem[rd_addr];
    end
    rd_tag <= rd_addr;
  end

  // Read valid flag: cleared in reset, set once reset is released
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= 1'b1;
    end
  end

  a_rd_valid_holds: assert property (@(posedge clk) disable iff (rst)
    rd_valid |=> rd_valid)
    else $error("read valid dropped outside reset");

endmodule

[hdl/mns_out_queue.sv]
// Two-entry result queue between the sequencer core and the output channel.
module mns_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mns_pkg::result_t  push_data,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output mns_pkg::result_t  out_data
);

  mns_pkg::result_t slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign room      = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slots[rd_ptr];

  // Payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> room)
    else $error("result pushed into a full queue");

  a_drain_count: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 2'd1))
    else $error("queue count wrong after a lone pop");

endmodule

[hdl/mns_core.sv]
// Sequencer core: playback, debounce and button actions around the song memory.
module mns_core #(
  parameter int SONG_DEPTH = 256,
  parameter int SONG_COUNT = 2
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  mns_pkg::cfg_t                               cfg,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [1:0]                                  op,
  input  logic [2:0]                                  button,
  input  logic                                        load_song,
  input  logic [7:0]                                  load_index,
  input  logic [15:0]                                 load_period,
  input  logic [9:0]                                  load_duration,
  output logic                                        mem_wr_en,
  output logic [$clog2(SONG_COUNT*SONG_DEPTH)-1:0]    mem_wr_addr,
  output mns_pkg::note_entry_t                        mem_wr_entry,
  output logic [$clog2(SONG_COUNT*SONG_DEPTH)-1:0]    mem_rd_addr,
  input  mns_pkg::note_entry_t                        mem_rd_entry,
  input  logic [$clog2(SONG_COUNT*SONG_DEPTH)-1:0]    mem_rd_tag,
  input  logic                                        mem_rd_valid,
  output logic                                        push,
  output mns_pkg::result_t                            result,
  input  logic                                        room
);

  localparam int PW = $clog2(SONG_DEPTH);
  localparam int XW = PW + 9;
  localparam int AW = $clog2(SONG_COUNT * SONG_DEPTH);
  localparam logic [XW-1:0] DEPTH_X = XW'(SONG_DEPTH);

  // Playback and button state
  logic [PW-1:0] pos [2];
  logic [17:0]   cnt [2];
  logic [7:0]    tempo;
  logic          sel;
  logic          playing;
  logic [7:0]    wait_cnt;
  logic [4:0]    pending;
  logic [1:0]    leds;
  logic [15:0]   tone;

  logic [PW-1:0] pos_next [2];
  logic [17:0]   cnt_next [2];
  logic [7:0]    tempo_next;
  logic          sel_next;
  logic          playing_next;
  logic [7:0]    wait_cnt_next;
  logic [4:0]    pending_next;
  logic [1:0]    leds_next;
  logic [15:0]   tone_next;

  logic [XW-1:0] len_raw;
  logic [XW-1:0] len;
  logic [XW-1:0] cur_pos;
  logic [XW-1:0] eff_pos;
  logic [XW-1:0] step_pos;
  logic [XW-1:0] idx_x;
  logic [17:0]   need;
  logic [25:0]   have;
  logic          due;
  logic          data_ok;
  logic          fire;
  logic          act;
  logic [8:0]    tempo_sum;
  logic [1:0]    song_bit;
  logic [PW+7:0] pos_wide;

  // Current note address, from the selected song and its clamped position
  always_comb begin
    len_raw = sel ? XW'(cfg.second_length) : XW'(cfg.first_length);
    if (len_raw == '0) begin
      len = XW'(1);
    end else if (len_raw > DEPTH_X) begin
      len = DEPTH_X;
    end else begin
      len = len_raw;
    end
    cur_pos     = XW'(pos[sel]);
    eff_pos     = (cur_pos >= len) ? '0 : cur_pos;
    step_pos    = ((eff_pos + XW'(1)) >= len) ? '0 : (eff_pos + XW'(1));
    mem_rd_addr = AW'(sel ? (eff_pos + DEPTH_X) : eff_pos);
  end

  // Note end test: counter * 256 against duration * tempo
  assign need     = 18'(mem_rd_entry.duration) * 18'(tempo);
  assign have     = {cnt[sel], 8'd0};
  assign due      = (have >= 26'(need));
  assign song_bit = sel ? 2'b10 : 2'b01;

  // A tick needs the entry of the current address in the read register
  assign data_ok  = mem_rd_valid && (mem_rd_tag == mem_rd_addr);
  assign in_ready = room && (data_ok || (op != mns_pkg::OP_TICK));
  assign fire     = in_valid && in_ready;
  assign push     = fire;

  // Load beats write the song memory
  assign idx_x        = XW'(load_index);
  assign mem_wr_en    = fire && (op == mns_pkg::OP_LOAD) && (idx_x < DEPTH_X)
                        && ((SONG_COUNT > 1) || !load_song);
  assign mem_wr_addr  = AW'(load_song ? (idx_x + DEPTH_X) : idx_x);
  assign mem_wr_entry = '{period: load_period, duration: load_duration};

  // Next state for one item
  always_comb begin
    pos_next      = pos;
    cnt_next      = cnt;
    tempo_next    = tempo;
    sel_next      = sel;
    playing_next  = playing;
    wait_cnt_next = wait_cnt;
    pending_next  = pending;
    leds_next     = leds;
    tone_next     = tone;
    tempo_sum     = '0;
    act           = 1'b0;

    if (fire) begin
      unique case (op)
        mns_pkg::OP_TICK: begin
          act       = 1'b1;
          tone_next = mem_rd_entry.period;
          if (playing && due) begin
            cnt_next[sel] = '0;
            pos_next[sel] = PW'(step_pos);
            tone_next     = 16'd1;
            leds_next     = leds ^ song_bit;
          end else begin
            pos_next[sel] = PW'(eff_pos);
            if (playing) begin
              cnt_next[sel] = cnt[sel] + 18'd1;
              leds_next     = leds | song_bit;
            end
          end
          if ((pending != '0) && (wait_cnt != 8'hFF)) begin
            wait_cnt_next = wait_cnt + 8'd1;
          end
        end
        mns_pkg::OP_PRESS: begin
          act = 1'b1;
          if (button <= mns_pkg::BTN_CHANGE) begin
            pending_next = pending | (5'(1) << button);
          end
        end
        default: begin
        end
      endcase
    end

    // Debounced press: act on one pending button, highest priority first
    if (act && (pending_next != '0) && (wait_cnt_next >= cfg.debounce)) begin
      priority if (pending_next[mns_pkg::BTN_PLAY]) begin
        playing_next                    = !playing_next;
        pending_next[mns_pkg::BTN_PLAY] = 1'b0;
      end else if (pending_next[mns_pkg::BTN_RESET]) begin
        tempo_next                       = cfg.tempo_default;
        pos_next[sel]                    = '0;
        cnt_next[sel]                    = '0;
        pending_next[mns_pkg::BTN_RESET] = 1'b0;
      end else if (pending_next[mns_pkg::BTN_SLOW]) begin
        if (tempo_next < cfg.slow_limit) begin
          tempo_sum  = 9'(tempo_next) + 9'(cfg.tempo_step);
          tempo_next = tempo_sum[8] ? 8'hFF : tempo_sum[7:0];
        end
        pending_next[mns_pkg::BTN_SLOW] = 1'b0;
      end else if (pending_next[mns_pkg::BTN_FAST]) begin
        if (tempo_next > cfg.fast_limit) begin
          tempo_next = (tempo_next > 8'(cfg.tempo_step))
                       ? (tempo_next - 8'(cfg.tempo_step)) : 8'd0;
        end
        pending_next[mns_pkg::BTN_FAST] = 1'b0;
      end else begin
        if (SONG_COUNT > 1) begin
          sel_next = !sel;
        end
        leds_next                         = sel_next ? 2'b10 : 2'b01;
        pending_next[mns_pkg::BTN_CHANGE] = 1'b0;
      end
      wait_cnt_next = '0;
    end
  end

  // Result beat shows the state after the item
  always_comb begin
    pos_wide = {8'd0, pos_next[sel_next]};
    result   = '{tone_period:   tone_next,
                 tone_enabled:  playing_next,
                 red_led:       leds_next[0],
                 green_led:     leds_next[1],
                 current_song:  sel_next,
                 note_position: pos_wide[7:0]};
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '{default: '0};
      cnt      <= '{default: '0};
      tempo    <= mns_pkg::RST_TEMPO_DEFAULT;
      sel      <= 1'b0;
      playing  <= 1'b1;
      wait_cnt <= '0;
      pending  <= '0;
      leds     <= 2'b01;
      tone     <= '0;
    end else begin
      pos      <= pos_next;
      cnt      <= cnt_next;
      tempo    <= tempo_next;
      sel      <= sel_next;
      playing  <= playing_next;
      wait_cnt <= wait_cnt_next;
      pending  <= pending_next;
      leds     <= leds_next;
      tone     <= tone_next;
    end
  end

  a_idle_wait_clear: assert property (@(posedge clk) disable iff (rst)
    (pending == '0) |-> (wait_cnt == '0))
    else $error("debounce count running with no press pending");

  a_tempo_only_on_beat: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(tempo))
    else $error("tempo changed without an accepted beat");

  a_tick_has_entry: assert property (@(posedge clk) disable iff (rst)
    (fire && (op == mns_pkg::OP_TICK)) |-> (mem_rd_tag == mem_rd_addr))
    else $error("tick played a stale song memory entry");

endmodule

[hdl/melody_note_sequencer.sv]
// Melody note sequencer: two songs held in one song memory, played one tick item at a
// time, with debounced buttons and a small register file. The block takes one item per
// clock cycle while the result queue has room. Besides a full queue, the only wait
// comes from the song memory's registered read: a tick that arrives in the cycle right
// after the selected note's address has changed (note advance, song reset, song change
// or a length write), or right after reset, is held while the new entry is read.
// Presses and loads never wait on the memory. Results go through a two-beat queue, so
// a stalled output does not hold the input until the queue is full. Song memory
// contents are undefined after reset until loaded; there is no clearing pass.
module melody_note_sequencer #(
  parameter int SONG_DEPTH = 256,
  parameter int SONG_COUNT = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [2:0]                    cfg_index,
  input  logic [mns_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    op,
  input  logic [2:0]                    button,
  input  logic                          load_song,
  input  logic [7:0]                    load_index,
  input  logic [15:0]                   load_period,
  input  logic [9:0]                    load_duration,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   tone_period,
  output logic                          tone_enabled,
  output logic                          red_led,
  output logic                          green_led,
  output logic                          current_song,
  output logic [7:0]                    note_position
);

  localparam int AW = $clog2(SONG_COUNT * SONG_DEPTH);

  mns_pkg::cfg_t        cfg;
  logic                 mem_wr_en;
  logic [AW-1:0]        mem_wr_addr;
  mns_pkg::note_entry_t mem_wr_entry;
  logic [AW-1:0]        mem_rd_addr;
  mns_pkg::note_entry_t mem_rd_entry;
  logic [AW-1:0]        mem_rd_tag;
  logic                 mem_rd_valid;
  logic                 push;
  mns_pkg::result_t     result;
  logic                 room;
  mns_pkg::result_t     out_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tempo_default <= mns_pkg::RST_TEMPO_DEFAULT;
      cfg.tempo_step    <= mns_pkg::RST_TEMPO_STEP;
      cfg.slow_limit    <= mns_pkg::RST_SLOW_LIMIT;
      cfg.fast_limit    <= mns_pkg::RST_FAST_LIMIT;
      cfg.debounce      <= mns_pkg::RST_DEBOUNCE;
      cfg.first_length  <= mns_pkg::RST_FIRST_LENGTH;
      cfg.second_length <= mns_pkg::RST_SECOND_LENGTH;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mns_pkg::CFG_TEMPO_DEFAULT: cfg.tempo_default <= cfg_data[7:0];
        mns_pkg::CFG_TEMPO_STEP:    cfg.tempo_step    <= cfg_data[5:0];
        mns_pkg::CFG_SLOW_LIMIT:    cfg.slow_limit    <= cfg_data[7:0];
        mns_pkg::CFG_FAST_LIMIT:    cfg.fast_limit    <= cfg_data[7:0];
        mns_pkg::CFG_DEBOUNCE:      cfg.debounce      <= cfg_data[7:0];
        mns_pkg::CFG_FIRST_LENGTH:  cfg.first_length  <= cfg_data[8:0];
        mns_pkg::CFG_SECOND_LENGTH: cfg.second_length <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  // Song memory
  mns_song_mem #(
    .SONG_DEPTH (SONG_DEPTH),
    .SONG_COUNT (SONG_COUNT)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (mem_wr_en),
    .wr_addr  (mem_wr_addr),
    .wr_entry (mem_wr_entry),
    .rd_addr  (mem_rd_addr),
    .rd_entry (mem_rd_entry),
    .rd_tag   (mem_rd_tag),
    .rd_valid (mem_rd_valid)
  );

  // Sequencer core
  mns_core #(
    .SONG_DEPTH (SONG_DEPTH),
    .SONG_COUNT (SONG_COUNT)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .button        (button),
    .load_song     (load_song),
    .load_index    (load_index),
    .load_period   (load_period),
    .load_duration (load_duration),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_entry  (mem_wr_entry),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_entry  (mem_rd_entry),
    .mem_rd_tag    (mem_rd_tag),
    .mem_rd_valid  (mem_rd_valid),
    .push          (push),
    .result        (result),
    .room          (room)
  );

  // Result queue
  mns_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign tone_period   = out_data.tone_period;
  assign tone_enabled  = out_data.tone_enabled;
  assign red_led       = out_data.red_led;
  assign green_led     = out_data.green_led;
  assign current_song  = out_data.current_song;
  assign note_position = out_data.note_position;

endmodule

[tb/mns_checker.sv]
// Checker for the melody note sequencer: tracks the block's state, predicts each beat, compares.
`timescale 1ns / 100ps

module mns_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [2:0]                     cfg_index,
  input  logic [mns_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [1:0]                     op,
  input  logic [2:0]                     button,
  input  logic                           load_song,
  input  logic [7:0]                     load_index,
  input  logic [15:0]                    load_period,
  input  logic [9:0]                     load_duration,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [15:0]                    tone_period,
  input  logic                           tone_enabled,
  input  logic                           red_led,
  input  logic                           green_led,
  input  logic                           current_song,
  input  logic [7:0]                     note_position,
  output int                             mismatches,
  output int                             awaiting
);
  import mns_pkg::*;

  localparam int SONG_DEPTH = 256;

  // Song memory as loaded so far
  logic [15:0] period_mem [0:2*SONG_DEPTH-1];
  logic [9:0]  dur_mem    [0:2*SONG_DEPTH-1];

  // Player state
  cfg_t        regs;
  logic [7:0]  pos_of     [2];
  logic [17:0] note_ticks [2];
  logic [7:0]  tempo;
  logic        song_sel;
  logic        running;
  logic [7:0]  press_wait;
  logic [4:0]  pending;
  logic [1:0]  leds;      // bit 0 red, bit 1 green
  logic [15:0] tone_reg;

  result_t expected_q [$];
  int      fail_count = 0;
  int      queued = 0;

  assign mismatches = fail_count;
  assign awaiting   = queued;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic restart();
    regs = {RST_TEMPO_DEFAULT, RST_TEMPO_STEP, RST_SLOW_LIMIT, RST_FAST_LIMIT,
            RST_DEBOUNCE, RST_FIRST_LENGTH, RST_SECOND_LENGTH};
    pos_of[0]     = '0;
    pos_of[1]     = '0;
    note_ticks[0] = '0;
    note_ticks[1] = '0;
    tempo         = RST_TEMPO_DEFAULT;
    song_sel      = 1'b0;
    running       = 1'b1;
    press_wait    = '0;
    pending       = '0;
    leds          = 2'b01;
    tone_reg      = '0;
    expected_q.delete();
  endtask

  task automatic set_reg(logic [2:0] idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_TEMPO_DEFAULT: regs.tempo_default = value[7:0];
      CFG_TEMPO_STEP:    regs.tempo_step    = value[5:0];
      CFG_SLOW_LIMIT:    regs.slow_limit    = value[7:0];
      CFG_FAST_LIMIT:    regs.fast_limit    = value[7:0];
      CFG_DEBOUNCE:      regs.debounce      = value[7:0];
      CFG_FIRST_LENGTH:  regs.first_length  = value[8:0];
      CFG_SECOND_LENGTH: regs.second_length = value[8:0];
      default: ;
    endcase
  endtask

  // Length in use: zero plays as one note, oversize clips to the memory depth
  function automatic int unsigned song_len(logic s);
    int unsigned n;
    n = 32'(s ? regs.second_length : regs.first_length);
    if (n == 0) n = 1;
    if (n > SONG_DEPTH) n = SONG_DEPTH;
    return n;
  endfunction

  // One tick: play the current note and, while running, advance it once its time is up
  task automatic play_tick();
    int unsigned      s;
    int unsigned      n;
    int unsigned      pos;
    int unsigned      addr;
    longint unsigned  need;
    longint unsigned  have;
    s    = 32'(song_sel);
    n    = song_len(song_sel);
    pos  = 32'(pos_of[s]);
    if (pos >= n) pos = 0;
    addr = s * SONG_DEPTH + pos;
    tone_reg = period_mem[addr];
    need = 64'(dur_mem[addr]) * 64'(tempo);
    have = 64'(note_ticks[s]) * 256;
    if (running && have >= need) begin
      note_ticks[s] = '0;
      pos++;
      if (pos >= n) pos = 0;
      tone_reg = 16'd1;
      leds[s]  = ~leds[s];
    end else if (running) begin
      note_ticks[s] = note_ticks[s] + 18'd1;
      leds[s]       = 1'b1;
    end
    pos_of[s] = pos[7:0];
    if (pending != '0 && press_wait != 8'hFF) press_wait++;
  endtask

  // Debounced press handling: one pending press per item, fixed priority
  task automatic act_on_press();
    int unsigned sum;
    if (pending == '0 || press_wait < regs.debounce) return;
    if (pending[BTN_PLAY]) begin
      running = ~running;
      pending[BTN_PLAY] = 1'b0;
    end else if (pending[BTN_RESET]) begin
      tempo = regs.tempo_default;
      pos_of[song_sel]     = '0;
      note_ticks[song_sel] = '0;
      pending[BTN_RESET] = 1'b0;
    end else if (pending[BTN_SLOW]) begin
      if (tempo < regs.slow_limit) begin
        sum   = 32'(tempo) + 32'(regs.tempo_step);
        tempo = (sum > 255) ? 8'hFF : sum[7:0];
      end
      pending[BTN_SLOW] = 1'b0;
    end else if (pending[BTN_FAST]) begin
      if (tempo > regs.fast_limit)
        tempo = (tempo > 8'(regs.tempo_step)) ? tempo - 8'(regs.tempo_step) : 8'd0;
      pending[BTN_FAST] = 1'b0;
    end else begin
      song_sel = ~song_sel;
      leds     = song_sel ? 2'b10 : 2'b01;
      pending[BTN_CHANGE] = 1'b0;
    end
    press_wait = '0;
  endtask

  task automatic apply_item();
    case (op)
      OP_TICK: begin
        play_tick();
        act_on_press();
      end
      OP_PRESS: begin
        if (button <= BTN_CHANGE) pending[button] = 1'b1;
        act_on_press();
      end
      OP_LOAD: begin
        period_mem[{load_song, load_index}] = load_period;
        dur_mem[{load_song, load_index}]    = load_duration;
      end
      default: ;
    endcase
  endtask

  function automatic result_t snapshot();
    result_t r;
    r.tone_period   = tone_reg;
    r.tone_enabled  = running;
    r.red_led       = leds[0];
    r.green_led     = leds[1];
    r.current_song  = song_sel;
    r.note_position = pos_of[song_sel];
    return r;
  endfunction

  task automatic check_beat(result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("unexpected beat", 32'(got), 32'd0);
      return;
    end
    want = expected_q.pop_front();
    if (got.tone_period !== want.tone_period)
      report_mismatch("tone_period", 32'(got.tone_period), 32'(want.tone_period));
    if (got.tone_enabled !== want.tone_enabled)
      report_mismatch("tone_enabled", 32'(got.tone_enabled), 32'(want.tone_enabled));
    if (got.red_led !== want.red_led)
      report_mismatch("red_led", 32'(got.red_led), 32'(want.red_led));
    if (got.green_led !== want.green_led)
      report_mismatch("green_led", 32'(got.green_led), 32'(want.green_led));
    if (got.current_song !== want.current_song)
      report_mismatch("current_song", 32'(got.current_song), 32'(want.current_song));
    if (got.note_position !== want.note_position)
      report_mismatch("note_position", 32'(got.note_position), 32'(want.note_position));
  endtask

  // Input beat is taken before the output beat so a same-edge result still lines up
  always @(posedge clk) begin
    if (rst) begin
      restart();
    end else begin
      if (cfg_write) set_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        apply_item();
        expected_q.push_back(snapshot());
      end
      if (out_valid && out_ready)
        check_beat({tone_period, tone_enabled, red_led, green_led, current_song,
                    note_position});
    end
    queued <= expected_q.size();
  end

endmodule

[tb/melody_note_sequencer_tb.sv]
// Testbench top for the melody note sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module melody_note_sequencer_tb;
  import mns_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [2:0] BTN_IGNORED = 3'd7;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 125;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [2:0]            cfg_index = CFG_TEMPO_DEFAULT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            op = OP_TICK;
  logic [2:0]            button = BTN_PLAY;
  logic                  load_song = 1'b0;
  logic [7:0]            load_index = '0;
  logic [15:0]           load_period = '0;
  logic [9:0]            load_duration = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [15:0]           tone_period;
  logic                  tone_enabled;
  logic                  red_led;
  logic                  green_led;
  logic                  current_song;
  logic [7:0]            note_position;

  int   mismatches;
  int   awaiting;
  int   gap_pct = 0;
  int   stall_pct = 0;
  logic hold_go = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  melody_note_sequencer u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .button        (button),
    .load_song     (load_song),
    .load_index    (load_index),
    .load_period   (load_period),
    .load_duration (load_duration),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .tone_period   (tone_period),
    .tone_enabled  (tone_enabled),
    .red_led       (red_led),
    .green_led     (green_led),
    .current_song  (current_song),
    .note_position (note_position)
  );

  mns_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .button        (button),
    .load_song     (load_song),
    .load_index    (load_index),
    .load_period   (load_period),
    .load_duration (load_duration),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .tone_period   (tone_period),
    .tone_enabled  (tone_enabled),
    .red_led       (red_led),
    .green_led     (green_led),
    .current_song  (current_song),
    .note_position (note_position),
    .mismatches    (mismatches),
    .awaiting      (awaiting)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off whenever hold_go flips
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one beat, after optional idle cycles, and wait for it to be taken
  task automatic send_item(logic [1:0] code, logic [2:0] btn, logic song, logic [7:0] idx,
                           logic [15:0] per, logic [9:0] dur);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    op            <= code;
    button        <= btn;
    load_song     <= song;
    load_index    <= idx;
    load_period   <= per;
    load_duration <= dur;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 3'($urandom), 1'($urandom), 8'($urandom), 16'($urandom),
              10'($urandom));
  endtask

  task automatic send_press(logic [2:0] btn);
    send_item(OP_PRESS, btn, 1'($urandom), 8'($urandom), 16'($urandom), 10'($urandom));
  endtask

  task automatic send_random();
    int unsigned pick;
    logic [2:0]  btn;
    logic [15:0] per;
    logic [9:0]  dur;
    pick = $urandom_range(99);
    btn  = ($urandom_range(9) == 0) ? 3'($urandom_range(BTN_IGNORED, BTN_CHANGE + 1))
                                    : 3'($urandom_range(BTN_CHANGE, BTN_PLAY));
    case ($urandom_range(9))
      0:       per = 16'd1;
      1:       per = '1;
      2:       per = '0;
      default: per = 16'($urandom);
    endcase
    // mostly short notes so that advances and wraps come often
    dur = ($urandom_range(4) == 0) ? 10'($urandom_range(1023, 0))
                                   : 10'($urandom_range(12, 0));
    if (pick < 60)
      send_item(OP_TICK, btn, 1'($urandom), 8'($urandom), per, dur);
    else if (pick < 78)
      send_item(OP_PRESS, btn, 1'($urandom), 8'($urandom), per, dur);
    else if (pick < 95)
      send_item(OP_LOAD, btn, 1'($urandom), 8'($urandom), per, dur);
    else
      send_item(OP_UNUSED, btn, 1'($urandom), 8'($urandom), per, dur);
  endtask

  // Let every expected beat come back, then keep the inputs idle while the block settles
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_regs(cfg_t c);
    logic [2:0] idx;
    for (idx = CFG_TEMPO_DEFAULT; idx <= CFG_SECOND_LENGTH; idx++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx;
      case (idx)
        CFG_TEMPO_DEFAULT: cfg_data <= CFG_DATA_W'(c.tempo_default);
        CFG_TEMPO_STEP:    cfg_data <= CFG_DATA_W'(c.tempo_step);
        CFG_SLOW_LIMIT:    cfg_data <= CFG_DATA_W'(c.slow_limit);
        CFG_FAST_LIMIT:    cfg_data <= CFG_DATA_W'(c.fast_limit);
        CFG_DEBOUNCE:      cfg_data <= CFG_DATA_W'(c.debounce);
        CFG_FIRST_LENGTH:  cfg_data <= c.first_length;
        default:           cfg_data <= c.second_length;
      endcase
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  // Register set per phase: fixed sets (reset values, small values, extremes) first, random afterwards
  function automatic cfg_t phase_regs(int p);
    cfg_t c;
    c.tempo_default = 8'($urandom_range(255, 0));
    c.tempo_step    = 6'($urandom_range(63, 0));
    c.slow_limit    = 8'($urandom_range(255, 0));
    c.fast_limit    = 8'($urandom_range(255, 0));
    c.debounce      = ($urandom_range(3) == 0) ? 8'($urandom_range(255, 0))
                                               : 8'($urandom_range(8, 0));
    c.first_length  = ($urandom_range(3) == 0) ? 9'($urandom_range(511, 0))
                                               : 9'($urandom_range(16, 1));
    c.second_length = ($urandom_range(3) == 0) ? 9'($urandom_range(511, 0))
                                               : 9'($urandom_range(16, 1));
    case (p)
      0: c = {RST_TEMPO_DEFAULT, RST_TEMPO_STEP, RST_SLOW_LIMIT, RST_FAST_LIMIT,
              RST_DEBOUNCE, RST_FIRST_LENGTH, RST_SECOND_LENGTH};
      1: c = {8'd8, 6'd3, 8'd40, 8'd2, 8'd2, 9'd5, 9'd9};
      2: c = {8'd255, 6'd63, 8'd255, 8'd255, 8'd255, 9'd0, 9'd511};
      3: c = {8'd0, 6'd1, 8'd1, 8'd0, 8'd0, 9'd256, 9'd1};
      4: c = {8'd1, 6'd0, 8'd128, 8'd128, 8'd1, 9'd2, 9'd2};
      default: ;
    endcase
    return c;
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Load every entry of both songs so no tick ever plays an empty slot
    for (int s = 0; s < 2; s++)
      for (int i = 0; i < 256; i++)
        send_item(OP_LOAD, 3'($urandom), s[0], i[7:0], 16'($urandom),
                  10'($urandom_range(6, 0)));
    drain();

    // Directed: field extremes, tempo saturation both ways, pause, song change
    program_regs({8'd1, 6'd63, 8'd255, 8'd1, 8'd0, 9'd3, 9'd256});
    send_item(OP_LOAD, BTN_PLAY, 1'b1, 8'hFF, 16'hFFFF, 10'h3FF);
    send_item(OP_LOAD, BTN_PLAY, 1'b0, 8'h00, 16'h0000, 10'h000);
    send_item(OP_LOAD, BTN_PLAY, 1'b0, 8'h01, 16'h0001, 10'h000);
    send_tick();
    send_tick();
    send_press(BTN_RESET);
    repeat (5) send_press(BTN_SLOW);
    repeat (5) send_press(BTN_FAST);
    send_tick();
    send_press(BTN_PLAY);
    send_tick();
    send_press(BTN_PLAY);
    send_press(BTN_CHANGE);
    send_tick();
    send_press(BTN_CHANGE);
    send_press(BTN_IGNORED);
    send_item(OP_UNUSED, 3'($urandom), 1'($urandom), 8'($urandom), 16'($urandom),
              10'($urandom));

    // Random phases, each with its own registers and idling pattern
    for (int p = 0; p < PHASES; p++) begin
      drain();
      program_regs(phase_regs(p));
      case (p % 4)
        0: begin
          gap_pct   <= 0;
          stall_pct <= 0;
        end
        1: begin
          gap_pct   <= 88;
          stall_pct <= 0;
        end
        2: begin
          gap_pct   <= 0;
          stall_pct <= 88;
        end
        default: begin
          gap_pct   <= 13;
          stall_pct <= 13;
        end
      endcase
      // long output hold-off while the sender keeps pushing
      if (p == 4) hold_go <= ~hold_go;
      repeat (PHASE_ITEMS) send_random();
    end
    drain();

    if (mismatches == 0 && awaiting == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #6400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[sim.f]
hdl/mns_pkg.sv
hdl/mns_song_mem.sv
hdl/mns_out_queue.sv
hdl/mns_core.sv
hdl/melody_note_sequencer.sv
tb/mns_checker.sv
tb/melody_note_sequencer_tb.sv
